/* rtl/core/lzsd_pkg.sv */
// Shared constants and controller/datapath handshake types for the LZSS decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lzsd_pkg;

  // Default token geometry
  localparam int LZSD_OFFSET_BITS = 13;
  localparam int LZSD_LENGTH_BITS = 4;
  localparam int LZSD_MIN_MATCH   = 3;

  // A literal token is one flag bit plus one byte
  localparam int LZSD_LIT_TOKEN_BITS = 9;

  // Configuration register map
  localparam int  LZSD_CFG_ADDR_W    = 3;
  localparam int  LZSD_CFG_DATA_W    = 32;
  localparam logic LZSD_REG_OUTPUT_SIZE = 1'b0;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take the input item, parse its bits
    logic rd;         // issue a dictionary read
    logic emit_lit;   // write and present the literal
    logic emit_copy;  // write and present the byte just read
  } lzsd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tok_lit;    // this item completes a literal token
    logic tok_match;  // this item completes a match token
    logic out_free;   // output register can take a byte
    logic final_byte; // the copy byte in hand ends the run
  } lzsd_status_t;

endpackage

/* rtl/core/lzsd_regs.sv */
// APB-style configuration register file for the LZSS decoder (output size).
// Depends on lzsd_pkg for the register map.
`timescale 1ns / 1ps

module lzsd_regs
  import lzsd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [LZSD_CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [LZSD_CFG_DATA_W-1:0] cfg_pwdata,
  output logic [LZSD_CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic [LZSD_CFG_DATA_W-1:0] output_size
);

  logic [LZSD_CFG_DATA_W-1:0] output_size_r;
  logic                       wr_en;
  logic                       sel_size;

  assign cfg_pready = 1'b1;
  assign sel_size   = (cfg_paddr[2] == LZSD_REG_OUTPUT_SIZE);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_size_r <= '0;
    end else if (wr_en && sel_size) begin
      output_size_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata  = sel_size ? output_size_r : '0;
  assign output_size = output_size_r;

endmodule

/* rtl/core/lzsd_ctrl.sv */
// Sequencing state machine of the LZSS decoder: accept, literal emit, copy read/write.
// Depends on lzsd_pkg for the command and status structs.
`timescale 1ns / 1ps

module lzsd_ctrl
  import lzsd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  lzsd_status_t st,
  output lzsd_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LIT  = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (st.tok_lit) begin
            state_nxt = S_LIT;
          end else if (st.tok_match) begin
            state_nxt = S_RD;
          end
        end
      end
      S_LIT: begin
        if (st.out_free) begin
          cmd.emit_lit = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        if (st.out_free) begin
          cmd.emit_copy = 1'b1;
          state_nxt     = st.final_byte ? S_IDLE : S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/lzsd_dpath.sv */
// Datapath of the LZSS decoder: bit buffer, token parse, ring dictionary, output register.
// Depends on lzsd_pkg; driven by lzsd_ctrl through command and status structs.
`timescale 1ns / 1ps

module lzsd_dpath
  import lzsd_pkg::*;
#(
  parameter int OFFSET_BITS = LZSD_OFFSET_BITS,
  parameter int LENGTH_BITS = LZSD_LENGTH_BITS,
  parameter int MIN_MATCH   = LZSD_MIN_MATCH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lzsd_cmd_t                  cmd,
  output lzsd_status_t               st,
  input  logic [7:0]                 in_byte,
  input  logic                       in_start,
  input  logic [LZSD_CFG_DATA_W-1:0] output_size,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,
  output logic                       out_tlast,
  output logic                       out_tuser
);

  localparam int TB   = 1 + OFFSET_BITS + LENGTH_BITS;  // match token bits
  localparam int HW   = $clog2(TB + 9);                 // holds up to TB+8
  localparam int IW   = $clog2(TB);
  localparam int LW   = LENGTH_BITS + 1;
  localparam int DICT = 1 << OFFSET_BITS;
  localparam int CW   = LZSD_CFG_DATA_W;

  // Bit buffer and counters
  logic [TB-1:0]          buf_r;
  logic [HW-1:0]          held_r;
  logic [OFFSET_BITS-1:0] head_r;
  logic [OFFSET_BITS:0]   fill_r;
  logic [CW-1:0]          emitted_r;

  // Current token
  logic [7:0]             lit_r;
  logic [OFFSET_BITS-1:0] rd_addr_r;
  logic [LW-1:0]          rem_r;

  // Dictionary read port
  logic [7:0]             mem [DICT];
  logic [7:0]             rdata_r;
  logic                   rvalid_r;

  // Output register
  logic                   out_valid_r;
  logic [7:0]             out_data_r;
  logic                   out_last_r;
  logic                   out_done_r;

  // Parse of the incoming byte
  logic [TB-1:0]   eff_buf;
  logic [HW-1:0]   eff_held;
  logic [CW-1:0]   eff_emitted;
  logic            active;
  logic [HW-1:0]   held_m1;
  logic            flag;
  logic [HW-1:0]   tok_len;
  logic [HW-1:0]   need;
  logic            complete;
  logic [3:0]      sh;
  logic [TB+7:0]   wide;
  logic [TB+7:0]   shifted;
  logic [TB-1:0]   full;
  logic [7:0]      tail;

  logic            emit;
  logic [7:0]      wdata;
  logic            done_now;
  logic            ends_run;
  logic            addr_written;

  always_comb begin
    eff_buf     = in_start ? '0 : buf_r;
    eff_held    = in_start ? '0 : held_r;
    eff_emitted = in_start ? '0 : emitted_r;
    active      = (eff_emitted < output_size);
    held_m1     = eff_held - HW'(1);
    flag        = (eff_held == '0) ? in_byte[7] : eff_buf[held_m1[IW-1:0]];
    tok_len     = flag ? HW'(LZSD_LIT_TOKEN_BITS) : HW'(TB);
    need        = tok_len - eff_held;
    complete    = (need <= HW'(8));
    sh          = 4'd8 - need[3:0];
    wide        = {eff_buf, in_byte};
    shifted     = wide >> sh;
    full        = shifted[TB-1:0];
    tail        = in_byte & (8'hFF >> need[3:0]);
  end

  assign st.tok_lit   = active & complete & flag;
  assign st.tok_match = active & complete & ~flag;
  assign st.out_free  = ~out_valid_r | out_tready;

  assign emit      = cmd.emit_lit | cmd.emit_copy;
  assign wdata     = cmd.emit_lit ? lit_r : (rvalid_r ? rdata_r : 8'h00);
  assign done_now  = ((emitted_r + CW'(1)) == output_size);
  assign st.final_byte = done_now | (rem_r == LW'(1));
  assign ends_run  = cmd.emit_lit | st.final_byte;

  // An entry never written since the last clear reads as zero
  assign addr_written = (rd_addr_r == '0) ? fill_r[OFFSET_BITS]
                                          : ({1'b0, rd_addr_r} <= fill_r);

  // Dictionary: write at the head on emit, registered read for copies
  always_ff @(posedge clk) begin
    if (emit) begin
      mem[head_r] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r  <= mem[rd_addr_r];
      rvalid_r <= addr_written;
    end
  end

  // Control state: buffer, head, fill count, byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r     <= '0;
      held_r    <= '0;
      head_r    <= OFFSET_BITS'(1);
      fill_r    <= '0;
      emitted_r <= '0;
    end else if (cmd.load) begin
      if (in_start) begin
        head_r    <= OFFSET_BITS'(1);
        fill_r    <= '0;
        emitted_r <= '0;
      end
      if (active) begin
        if (complete) begin
          buf_r  <= TB'(tail);
          held_r <= HW'(sh);
        end else begin
          buf_r  <= wide[TB-1:0];
          held_r <= eff_held + HW'(8);
        end
      end else if (in_start) begin
        buf_r  <= '0;
        held_r <= '0;
      end
    end else if (emit) begin
      head_r    <= head_r + OFFSET_BITS'(1);
      emitted_r <= emitted_r + CW'(1);
      if (!fill_r[OFFSET_BITS]) begin
        fill_r <= fill_r + (OFFSET_BITS + 1)'(1);
      end
      // Drop leftover bits once the entry is complete
      if (ends_run && done_now) begin
        buf_r  <= '0;
        held_r <= '0;
      end
    end
  end

  // Token payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lit_r     <= full[7:0];
      rd_addr_r <= full[OFFSET_BITS+LENGTH_BITS-1:LENGTH_BITS];
      rem_r     <= LW'(full[LENGTH_BITS-1:0]) + LW'(MIN_MATCH);
    end else if (cmd.emit_copy) begin
      rd_addr_r <= rd_addr_r + OFFSET_BITS'(1);
      rem_r     <= rem_r - LW'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= wdata;
      out_last_r <= ends_run;
      out_done_r <= done_now;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

/* rtl/core/lzss_byte_stream_decoder.sv */
// Top level of the LZSS byte stream decoder: register file, controller and datapath.
// Depends on lzsd_pkg, lzsd_regs, lzsd_ctrl and lzsd_dpath.
`timescale 1ns / 1ps

// The decoder takes compressed bytes on the input stream, most significant
// bit first, and returns decompressed bytes on the output stream. A flag bit
// of 1 introduces an 8-bit literal; a flag bit of 0 introduces an absolute
// dictionary offset of OFFSET_BITS and a length of LENGTH_BITS, copied as
// length + MIN_MATCH bytes from a 2^OFFSET_BITS byte ring dictionary whose
// write head starts at 1. Set in_tuser on the first byte of an entry to
// clear the dictionary, head, bit buffer and byte count. Program output_size
// (byte address 0) while the block is idle; decoding stops once that many
// bytes are out, the rest of a match is dropped and further input is
// swallowed until the next start. out_tlast marks the last byte caused by
// one input item, out_tuser the byte that completes the entry. An input item
// that completes no token is only accepted; a literal then passes through the
// literal emit state, and a match runs through a dictionary read state and a
// write/emit state for each copied byte on the single-port dictionary memory.
// Output backpressure stalls the emit states. The dictionary clear on start is
// a fill count, so there is no clearing pass on start or after reset.
module lzss_byte_stream_decoder
  import lzsd_pkg::*;
#(
  parameter int OFFSET_BITS = LZSD_OFFSET_BITS,
  parameter int LENGTH_BITS = LZSD_LENGTH_BITS,
  parameter int MIN_MATCH   = LZSD_MIN_MATCH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,    // [7:0] compressed_byte
  input  logic                       in_tuser,    // [0] start_req
  // Output stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,   // [7:0] out_byte
  output logic                       out_tlast,   // last_of_run
  output logic                       out_tuser,   // [0] entry_done
  // Configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [LZSD_CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [LZSD_CFG_DATA_W-1:0] cfg_pwdata,
  output logic [LZSD_CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [LZSD_CFG_DATA_W-1:0] output_size;
  lzsd_cmd_t                  cmd;
  lzsd_status_t               st;

  // Configuration registers
  lzsd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .output_size (output_size)
  );

  // Sequencer: accept one item, then run its token out byte by byte
  lzsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // Bit buffer, dictionary and output register
  lzsd_dpath #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .MIN_MATCH   (MIN_MATCH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .st          (st),
    .in_byte     (in_tdata),
    .in_start    (in_tuser),
    .output_size (output_size),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule
